/* rtl/core/lkv_pkg.sv */
// Shared types and constants for the LRU key/value cache.
package lkv_pkg;

  localparam int KEY_W        = 16;
  localparam int VALUE_W      = 16;
  localparam int CFG_W        = 5;
  localparam int CAPACITY_DEF = 16;
  localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(16);

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [KEY_W-1:0]   lookup_key;
    logic [VALUE_W-1:0] write_value;
  } lkv_req_t;

  typedef struct packed {
    logic               found;
    logic [VALUE_W-1:0] read_value;
    logic               evicted;
  } lkv_rsp_t;

endpackage

/* rtl/core/lkv_cell.sv */
// One recency position of the cache: holds a key/value pair and compares its key.
module lkv_cell
  import lkv_pkg::*;
(
  input  logic               clk,
  input  logic               cmp_en,
  input  logic               upd_en,
  input  logic               entry_valid,
  input  logic [KEY_W-1:0]   req_key,
  input  logic [KEY_W-1:0]   in_key,
  input  logic [VALUE_W-1:0] in_value,
  output logic [KEY_W-1:0]   key_r,
  output logic [VALUE_W-1:0] value_r,
  output logic               match_r
);

  always_ff @(posedge clk) begin
    if (cmp_en) begin
      match_r <= entry_valid && (key_r == req_key);
    end
    if (upd_en) begin
      key_r   <= in_key;
      value_r <= in_value;
    end
  end

endmodule

/* rtl/core/lkv_sel.sv */
// Gathers the per-cell match flags into a hit flag, hit position and hit value.
module lkv_sel
  import lkv_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic               clk,
  input  logic               sel_en,
  input  logic [CAPACITY-1:0] match,
  input  logic [VALUE_W-1:0] values [CAPACITY],
  output logic               hit_r,
  output logic [IDX_W-1:0]   hit_idx_r,
  output logic [VALUE_W-1:0] hit_value_r
);

  logic [IDX_W-1:0]   idx_or;
  logic [VALUE_W-1:0] value_or;

  // Keys held in the row are unique, so at most one flag is set and a plain OR selects.
  always_comb begin
    idx_or   = '0;
    value_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match[i]) begin
        idx_or   = idx_or | IDX_W'(i);
        value_or = value_or | values[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel_en) begin
      hit_r       <= |match;
      hit_idx_r   <= idx_or;
      hit_value_r <= value_or;
    end
  end

endmodule

/* rtl/core/lru_key_value_cache_top.sv */
// Top level of the fully associative LRU key/value cache built as a row of recency cells.
//
// The cache keeps its entries in a row of cells ordered by recency, cell 0 holding the most
// recent entry and the occupied cells always forming an unbroken run from cell 0. Each request
// (get or put) passes through the states IDLE, in which it is accepted, CMP, a parallel key
// compare in every cell, SEL, selection of the hit, and UPD, one shift of the row that moves
// the touched entry to the front and loads the result into the output register. The next
// request is accepted in the cycle after the result is loaded, so the block takes no new
// request before it is through with the last; a result held back by out_stall delays the
// shift until the output register is free. The table is empty after reset with no clearing
// pass. The cfg port is always ready and sets how many entries are held before a put on a new
// key evicts the least recent one (zero acts as one, values above CAPACITY act as CAPACITY).
module lru_key_value_cache_top
  import lkv_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  lkv_req_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output lkv_rsp_t         out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_SEL  = 2'd2;
  localparam logic [1:0] ST_UPD  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  lkv_req_t          req_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CFG_W-1:0]  active_r;
  lkv_rsp_t          out_r, out_nxt;
  logic              out_valid_r;

  logic [KEY_W-1:0]    cell_key   [CAPACITY];
  logic [VALUE_W-1:0]  cell_value [CAPACITY];
  logic [CAPACITY-1:0] match;

  logic               hit_r;
  logic [IDX_W-1:0]   hit_idx_r;
  logic [VALUE_W-1:0] hit_value_r;

  logic               upd_fire;
  logic               miss_put;
  logic               need_evict;
  logic [LIM_W-1:0]   act_ext;
  logic [LIM_W-1:0]   limit;
  logic [VALUE_W-1:0] head_value;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  assign upd_fire = (state_r == ST_UPD) && (!out_valid_r || !out_stall);
  assign miss_put = !hit_r && (req_r.cmd == CMD_PUT);

  // Effective limit: zero behaves as one, anything beyond the row length as the row length.
  always_comb begin
    act_ext = LIM_W'(active_r);
    if (act_ext == '0) begin
      limit = LIM_W'(1);
    end else if (act_ext > LIM_W'(CAPACITY)) begin
      limit = LIM_W'(CAPACITY);
    end else begin
      limit = act_ext;
    end
  end

  assign need_evict = (LIM_W'(count_r) >= limit);
  assign head_value = (req_r.cmd == CMD_PUT) ? req_r.write_value : hit_value_r;

  // Row of cells; on a shift each cell takes its neighbour's entry, cell 0 takes the request.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic               shift_en;
    logic [KEY_W-1:0]   src_key;
    logic [VALUE_W-1:0] src_value;

    if (i == 0) begin : g_head
      assign src_key   = req_r.lookup_key;
      assign src_value = head_value;
    end else begin : g_body
      assign src_key   = cell_key[i-1];
      assign src_value = cell_value[i-1];
    end

    assign shift_en = upd_fire && (miss_put || (hit_r && (IDX_W'(i) <= hit_idx_r)));

    lkv_cell u_cell (
      .clk         (clk),
      .cmp_en      (state_r == ST_CMP),
      .upd_en      (shift_en),
      .entry_valid (CNT_W'(i) < count_r),
      .req_key     (req_r.lookup_key),
      .in_key      (src_key),
      .in_value    (src_value),
      .key_r       (cell_key[i]),
      .value_r     (cell_value[i]),
      .match_r     (match[i])
    );
  end

  lkv_sel #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W)
  ) u_sel (
    .clk         (clk),
    .sel_en      (state_r == ST_SEL),
    .match       (match),
    .values      (cell_value),
    .hit_r       (hit_r),
    .hit_idx_r   (hit_idx_r),
    .hit_value_r (hit_value_r)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP:  state_nxt = ST_SEL;
      ST_SEL:  state_nxt = ST_UPD;
      ST_UPD: begin
        if (upd_fire) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (upd_fire && miss_put && !need_evict) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_comb begin
    out_nxt.found      = hit_r;
    out_nxt.read_value = (hit_r && (req_r.cmd == CMD_GET)) ? hit_value_r : '0;
    out_nxt.evicted    = miss_put && need_evict;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      active_r    <= ACTIVE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_valid && cfg_ready) begin
        active_r <= cfg_data;
      end
      if (upd_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      req_r <= in_data;
    end
    if (upd_fire) begin
      out_r <= out_nxt;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    LIM_W'(count_r) <= LIM_W'(CAPACITY))
    else $error("occupancy exceeds the row length");

  a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEL) |-> $onehot0(match))
    else $error("more than one cell matched the request key");

  a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_fire && miss_put && !need_evict) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert without eviction did not add an entry");

  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (count_r >= $past(count_r)))
    else $error("occupancy decreased without reset");

  a_evict_only_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.found && out_r.evicted))
    else $error("eviction reported on a request that hit");
`endif

endmodule
